[sv/rtpi_pkg.sv]
// ----------------------------------------------------------------------------
// RGB to terminal palette index: shared package
// Palette mode codes, threshold tables and the words passed between stages.
// ----------------------------------------------------------------------------
package rtpi_pkg;

   // Palette mode codes held in the configuration register.
   localparam logic [2:0] MODE_8     = 3'd0;
   localparam logic [2:0] MODE_16    = 3'd1;
   localparam logic [2:0] MODE_88    = 3'd2;
   localparam logic [2:0] MODE_256   = 3'd3;
   localparam logic [2:0] MODE_RESET = MODE_256;

   // Grey ramp detection window.
   localparam logic [7:0] GREY_LOW  = 8'd8;
   localparam logic [7:0] GREY_HIGH = 8'd238;
   localparam logic [7:0] MID_GREY  = 8'd128;
   localparam logic [7:0] FULL      = 8'd255;

   // Palette base indices.
   localparam logic [8:0] CUBE_BASE     = 9'd16;
   localparam logic [8:0] GREY88_BASE   = 9'd80;
   localparam logic [8:0] GREY256_BASE  = 9'd232;
   localparam logic [8:0] BRIGHT_BASE   = 9'd8;
   localparam logic [8:0] INDEX_INVALID = 9'h1FF;
   localparam logic [8:0] PAIR_INVALID  = 9'd0;

   // Grey ramp step counts: the 88-color ramp holds 7 steps above its base
   // (the eighth is clamped away), the 256-color ramp holds 23.
   localparam int GREY88_STEPS  = 7;
   localparam int GREY256_STEPS = 23;

   // Smallest red level that reaches each ramp step. For the 88-color ramp
   // step k is reached when 16r + 238 >= 476k; for the 256-color ramp when
   // 24r >= 238k.
   localparam logic [7:0] GREY88_STEP [GREY88_STEPS] = '{
      8'd15, 8'd45, 8'd75, 8'd105, 8'd134, 8'd164, 8'd194
   };
   localparam logic [7:0] GREY256_STEP [GREY256_STEPS] = '{
      8'd10,  8'd20,  8'd30,  8'd40,  8'd50,  8'd60,  8'd70,  8'd80,
      8'd90,  8'd100, 8'd110, 8'd119, 8'd129, 8'd139, 8'd149, 8'd159,
      8'd169, 8'd179, 8'd189, 8'd199, 8'd209, 8'd219, 8'd229
   };

   // One pixel word with the palette mode that was active when it came in.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] mode;
   } pixel_type;

   // Per-pixel classification handed from the classify stage to the index stage.
   typedef struct packed {
      logic [2:0]                 mode;
      logic                       grey;
      logic                       mid_grey;
      logic                       bright;
      logic [2:0]                 basic;
      logic [1:0]                 lvl4_red;
      logic [1:0]                 lvl4_green;
      logic [1:0]                 lvl4_blue;
      logic [2:0]                 lvl6_red;
      logic [2:0]                 lvl6_green;
      logic [2:0]                 lvl6_blue;
      logic [GREY88_STEPS-1:0]    therm88;
      logic [GREY256_STEPS-1:0]   therm256;
   } class_type;

   // Cube level for a 4-level cube: max(floor(4c/255) - 1, 0).
   function automatic logic [1:0] cube_level4(input logic [7:0] c);
      logic [1:0] lvl;
      if (c == FULL)         lvl = 2'd3;
      else if (c >= 8'd192)  lvl = 2'd2;
      else if (c >= 8'd128)  lvl = 2'd1;
      else                   lvl = 2'd0;
      return lvl;
   endfunction

   // Cube level for a 6-level cube: max(floor(6c/255) - 1, 0).
   function automatic logic [2:0] cube_level6(input logic [7:0] c);
      logic [2:0] lvl;
      if (c == FULL)         lvl = 3'd5;
      else if (c >= 8'd213)  lvl = 3'd4;
      else if (c >= 8'd170)  lvl = 3'd3;
      else if (c >= 8'd128)  lvl = 3'd2;
      else if (c >= 8'd85)   lvl = 3'd1;
      else                   lvl = 3'd0;
      return lvl;
   endfunction

endpackage

[sv/rtpi_classify.sv]
// ----------------------------------------------------------------------------
// RGB to terminal palette index: classify stage
// Compares each channel against the cube and grey ramp thresholds and
// registers the resulting flags, levels and thermometer codes.
// ----------------------------------------------------------------------------
module rtpi_classify
   import rtpi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pixel_type in_pixel,
   output logic      out_valid,
   input  logic      out_ready,
   output class_type out_class
);

   logic      valid_ff;
   logic      valid_in;
   class_type class_ff;
   class_type class_in;
   logic      black;
   logic      all_edge;

   // The stage moves on when it is empty or its word is being taken.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Channel classification.
   always_comb begin
      black    = (in_pixel.red == 8'd0) && (in_pixel.green == 8'd0) &&
                 (in_pixel.blue == 8'd0);
      all_edge = ((in_pixel.red == 8'd0) || (in_pixel.red == FULL)) &&
                 ((in_pixel.green == 8'd0) || (in_pixel.green == FULL)) &&
                 ((in_pixel.blue == 8'd0) || (in_pixel.blue == FULL));

      class_in.mode       = in_pixel.mode;
      class_in.grey       = (in_pixel.red >= GREY_LOW) && (in_pixel.red <= GREY_HIGH) &&
                            (in_pixel.red == in_pixel.green) &&
                            (in_pixel.red == in_pixel.blue);
      class_in.mid_grey   = (in_pixel.red == MID_GREY) && (in_pixel.green == MID_GREY) &&
                            (in_pixel.blue == MID_GREY);
      class_in.bright     = all_edge && !black;
      class_in.basic      = {in_pixel.blue != 8'd0, in_pixel.green != 8'd0,
                             in_pixel.red != 8'd0};
      class_in.lvl4_red   = cube_level4(in_pixel.red);
      class_in.lvl4_green = cube_level4(in_pixel.green);
      class_in.lvl4_blue  = cube_level4(in_pixel.blue);
      class_in.lvl6_red   = cube_level6(in_pixel.red);
      class_in.lvl6_green = cube_level6(in_pixel.green);
      class_in.lvl6_blue  = cube_level6(in_pixel.blue);

      // Grey ramp steps as thermometer codes; each bit is one compare.
      for (int k = 0; k < GREY88_STEPS; k++) begin
         class_in.therm88[k] = in_pixel.red >= GREY88_STEP[k];
      end
      for (int k = 0; k < GREY256_STEPS; k++) begin
         class_in.therm256[k] = in_pixel.red >= GREY256_STEP[k];
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         class_ff <= class_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_class = class_ff;

endmodule

[sv/rtpi_index.sv]
// ----------------------------------------------------------------------------
// RGB to terminal palette index: index stage
// Forms the palette index and pair number from the classified pixel and
// holds them in the output register.
// ----------------------------------------------------------------------------
module rtpi_index
   import rtpi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  class_type         in_class,
   output logic              out_valid,
   input  logic              out_ready,
   output logic signed [8:0] out_color_index,
   output logic        [8:0] out_color_pair
);

   logic       valid_ff;
   logic       valid_in;
   logic [8:0] index_ff;
   logic [8:0] index_in;
   logic [8:0] pair_ff;
   logic [8:0] pair_in;
   logic [8:0] cube88;
   logic [8:0] cube256;
   logic [8:0] grey88;
   logic [8:0] grey256;
   logic [8:0] basic_idx;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Candidate indices for every palette, then a select by mode.
   always_comb begin
      basic_idx = {6'd0, in_class.basic};
      cube88    = CUBE_BASE + {7'd0, in_class.lvl4_blue} +
                  {5'd0, in_class.lvl4_green, 2'd0} +
                  {3'd0, in_class.lvl4_red, 4'd0};
      cube256   = CUBE_BASE + {6'd0, in_class.lvl6_blue} +
                  ({6'd0, in_class.lvl6_green} * 9'd6) +
                  ({6'd0, in_class.lvl6_red} * 9'd36);
      grey88    = GREY88_BASE + 9'($countones(in_class.therm88));
      grey256   = GREY256_BASE + 9'($countones(in_class.therm256));

      unique case (in_class.mode)
         MODE_8: begin
            index_in = basic_idx;
         end
         MODE_16: begin
            if (in_class.mid_grey)    index_in = BRIGHT_BASE;
            else if (in_class.bright) index_in = BRIGHT_BASE + basic_idx;
            else                      index_in = basic_idx;
         end
         MODE_88: begin
            index_in = in_class.grey ? grey88 : cube88;
         end
         MODE_256: begin
            index_in = in_class.grey ? grey256 : cube256;
         end
         default: begin
            index_in = INDEX_INVALID;
         end
      endcase

      // The pair number follows the index, zero for an unsupported size.
      pair_in = (index_in == INDEX_INVALID) ? PAIR_INVALID : index_in + 9'd1;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         index_ff <= index_in;
         pair_ff  <= pair_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_color_index = $signed(index_ff);
   assign out_color_pair  = pair_ff;

   // The pair number is zero exactly when the index is the invalid code.
   a_pair_zero : assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ((out_color_pair == PAIR_INVALID) ==
                     (index_ff == INDEX_INVALID)))
      else $error("pair number zero does not match invalid index");

   // A valid index always has the next pair number.
   a_pair_next : assert property (@(posedge clock) disable iff (reset)
      (out_valid && (index_ff != INDEX_INVALID)) |->
         (out_color_pair == 9'(index_ff + 9'd1)))
      else $error("pair number is not index plus one");

   // A stalled result word stays in the output register.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(index_ff) && $stable(pair_ff)))
      else $error("stalled result word was lost or changed");

   // An unsupported mode never reaches the output as a real index.
   a_unsupported : assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && (in_class.mode != MODE_8) && (in_class.mode != MODE_16) &&
       (in_class.mode != MODE_88) && (in_class.mode != MODE_256)) |=>
         (index_ff == INDEX_INVALID))
      else $error("unsupported mode gave a palette index");

endmodule

[sv/rgb_to_terminal_palette_index_core.sv]
// ----------------------------------------------------------------------------
// RGB to terminal palette index core
// Maps a 24-bit RGB pixel to an 8, 16, 88 or 256 color terminal palette
// index and its color pair number.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the req_ channel (valid/ready) as red, green and blue
//   bytes. One result word per pixel leaves on the rsp_ channel (valid/ready)
//   with the signed palette index (-1 for an unsupported palette size) and
//   the pair number (index plus one, or zero).
//   csr_we with csr_wdata writes the palette mode: 0 = 8 colors, 1 = 16,
//   2 = 88, 3 = 256, anything else unsupported. Write it only while no pixel
//   is in flight; each pixel carries the mode it was accepted under.
//   The pipeline has three register stages: input, classify (threshold
//   compares), index (cube sums and select). A pixel passes the input,
//   classify and index registers in that order before it shows on rsp_;
//   one pixel per cycle is sustained while rsp_ready stays high.
//   Each stage holds its word while the next one is full and stalled, so a
//   receiver stall backs up through req_ready without loss or repeats.
//   Reset empties all stages and sets the mode to 256 colors.
// ----------------------------------------------------------------------------
module rgb_to_terminal_palette_index_core
   import rtpi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic        [7:0] req_red,
   input  logic        [7:0] req_green,
   input  logic        [7:0] req_blue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [8:0] rsp_color_index,
   output logic        [8:0] rsp_color_pair,
   input  logic              csr_we,
   input  logic        [2:0] csr_wdata
);

   logic      mode_ff;
   logic [2:0] palette_mode_ff;
   logic      in_valid_ff;
   logic      in_valid_in;
   pixel_type pixel_ff;
   logic      cls_ready;
   logic      cls_valid;
   logic      idx_ready;
   class_type cls_word;

   // Palette mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_mode_ff <= MODE_RESET;
      end else if (csr_we) begin
         palette_mode_ff <= csr_wdata;
      end
   end

   // Input stage: captures the pixel word with the active mode.
   assign req_ready   = !in_valid_ff || cls_ready;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pixel_ff.red   <= req_red;
         pixel_ff.green <= req_green;
         pixel_ff.blue  <= req_blue;
         pixel_ff.mode  <= palette_mode_ff;
      end
   end

   // Pipeline marker: set once any pixel has ever been accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         mode_ff <= 1'b1;
      end
   end

   rtpi_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (cls_ready),
      .in_pixel  (pixel_ff),
      .out_valid (cls_valid),
      .out_ready (idx_ready),
      .out_class (cls_word)
   );

   rtpi_index u_index (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (cls_valid),
      .in_ready        (idx_ready),
      .in_class        (cls_word),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_color_index (rsp_color_index),
      .out_color_pair  (rsp_color_pair)
   );

   // No result word can appear before any pixel word was taken.
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> mode_ff)
      else $error("result word without any accepted pixel word");

   // Right after reset the pipeline is empty.
   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !in_valid_ff && !cls_valid))
      else $error("pipeline not empty after reset");

   // An empty input stage always takes a pixel word.
   a_empty_takes : assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("empty input stage refused a pixel word");

endmodule

[verif/rtpi_checker.sv]
// ----------------------------------------------------------------------------
// RGB to terminal palette index: result checker
// Watches the pixel and result channels and the mode register port. It
// predicts the palette index and pair number of every accepted pixel word
// under the mode in force, and compares each result word in order.
// ----------------------------------------------------------------------------
module rtpi_checker
   import rtpi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic        [7:0] req_red,
   input  logic        [7:0] req_green,
   input  logic        [7:0] req_blue,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic signed [8:0] rsp_color_index,
   input  logic        [8:0] rsp_color_pair,
   input  logic              csr_we,
   input  logic        [2:0] csr_wdata,
   output int                pending_words,
   output int                mismatch_count
);

   // One predicted result word.
   typedef struct packed {
      logic signed [8:0] color_index;
      logic        [8:0] color_pair;
   } palette_result_type;

   palette_result_type palette_q[$];
   logic [2:0]         mode_shadow;
   int                 queued_words = 0;
   int                 error_total  = 0;

   assign pending_words  = queued_words;
   assign mismatch_count = error_total;

   // Cube level of one channel: max(floor(c * levels / 255) - 1, 0).
   function automatic int unsigned cube_step(input logic [7:0] c, input int unsigned levels);
      int unsigned q;
      q = (int'(c) * levels) / 255;
      return (q > 0) ? q - 1 : 0;
   endfunction

   // Basic 8-color index: one bit per non-zero channel.
   function automatic int unsigned basic_color(input logic [7:0] r, g, b);
      return ((r != 0) ? 1 : 0) + ((g != 0) ? 2 : 0) + ((b != 0) ? 4 : 0);
   endfunction

   // Every channel is either off or at full intensity.
   function automatic bit saturated(input logic [7:0] r, g, b);
      return (r == 8'd0 || r == FULL) && (g == 8'd0 || g == FULL) && (b == 8'd0 || b == FULL);
   endfunction

   // Expected result word for one pixel under a palette mode.
   function automatic palette_result_type predict_palette(input logic [2:0] mode,
                                                          input logic [7:0] r, g, b);
      int unsigned        idx;
      bit                 grey;
      palette_result_type res;
      grey = (r >= 8'd8) && (r <= 8'd238) && (r == g) && (r == b);
      idx  = 0;
      case (mode)
         MODE_8: begin
            idx = basic_color(r, g, b);
         end
         MODE_16: begin
            if (r == MID_GREY && g == MID_GREY && b == MID_GREY)
               idx = 8;
            else if ((r | g | b) != 8'd0 && saturated(r, g, b))
               idx = 8 + basic_color(r, g, b);
            else
               idx = basic_color(r, g, b);
         end
         MODE_88: begin
            if (grey) begin
               idx = 80 + (16 * int'(r) + 238) / 476;
               if (idx > 87) idx = 87;
            end else begin
               idx = 16 + cube_step(b, 4) + 4 * cube_step(g, 4) + 16 * cube_step(r, 4);
            end
         end
         MODE_256: begin
            if (grey) begin
               idx = 232 + (24 * int'(r)) / 238;
               if (idx > 255) idx = 255;
            end else begin
               idx = 16 + cube_step(b, 6) + 6 * cube_step(g, 6) + 36 * cube_step(r, 6);
            end
         end
         default: begin
            res.color_index = INDEX_INVALID;
            res.color_pair  = PAIR_INVALID;
            return res;
         end
      endcase
      res.color_index = idx[8:0];
      res.color_pair  = idx[8:0] + 9'd1;
      return res;
   endfunction

   // Track the mode register, queue predictions and check result words.
   always @(posedge clock) begin
      palette_result_type want;
      if (reset) begin
         mode_shadow = MODE_RESET;
         palette_q.delete();
      end else begin
         if (req_valid && req_ready)
            palette_q.push_back(predict_palette(mode_shadow, req_red, req_green, req_blue));
         if (rsp_valid && rsp_ready) begin
            if (palette_q.size() == 0) begin
               $error("unexpected result word: color_index %0d color_pair %0d",
                      rsp_color_index, rsp_color_pair);
               error_total++;
            end else begin
               want = palette_q.pop_front();
               if (rsp_color_index !== want.color_index) begin
                  $error("color_index: expected %0d, actual %0d",
                         want.color_index, rsp_color_index);
                  error_total++;
               end
               if (rsp_color_pair !== want.color_pair) begin
                  $error("color_pair: expected %0d, actual %0d",
                         want.color_pair, rsp_color_pair);
                  error_total++;
               end
            end
         end
         if (csr_we)
            mode_shadow = csr_wdata;
      end
      queued_words <= palette_q.size();
   end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// RGB to terminal palette index: testbench top
// Drives pixel words and palette mode writes into the core, applies random
// sender gaps and receiver stalls, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top
   import rtpi_pkg::*;
();

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic        [7:0] req_red = 8'd0;
   logic        [7:0] req_green = 8'd0;
   logic        [7:0] req_blue = 8'd0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [8:0] rsp_color_index;
   logic        [8:0] rsp_color_pair;
   logic              csr_we = 1'b0;
   logic        [2:0] csr_wdata = 3'd0;

   int pending_words;
   int mismatch_count;
   int idle_pct  = 0;
   int stall_pct = 0;

   // Channel levels near the thresholds of the ramps, cubes and 16-color rules.
   localparam logic [7:0] CORNER_LEVELS [24] = '{
      8'd0,   8'd1,   8'd7,   8'd8,   8'd9,   8'd10,  8'd14,  8'd15,
      8'd84,  8'd85,  8'd127, 8'd128, 8'd129, 8'd169, 8'd170, 8'd191,
      8'd192, 8'd212, 8'd213, 8'd229, 8'd238, 8'd239, 8'd254, 8'd255
   };

   // Directed pixels: black, white, mid grey, ramp edges, primaries, near misses.
   localparam logic [23:0] DIRECTED_PIXELS [20] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h080808, 24'h070707,
      24'hEEEEEE, 24'hEFEFEF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h010000, 24'h7F8081, 24'h0F0F0F, 24'h0E0E0E,
      24'hE8E8E8, 24'hE5E5E5, 24'hFF8000, 24'hAAD555, 24'h80807F
   };

   // Palette mode per random segment; covers every register value.
   localparam logic [2:0] MODE_PLAN [12] = '{
      MODE_8, MODE_16, MODE_88, MODE_256, 3'd4, 3'd5, 3'd6, 3'd7,
      MODE_256, MODE_88, MODE_16, MODE_8
   };

   // Sender gap and receiver stall percentages per idling phase.
   localparam int IDLE_PLAN  [4] = '{0, 77, 0, 22};
   localparam int STALL_PLAN [4] = '{0, 0, 77, 22};

   rgb_to_terminal_palette_index_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_color_index (rsp_color_index),
      .rsp_color_pair  (rsp_color_pair),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   rtpi_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_color_index (rsp_color_index),
      .rsp_color_pair  (rsp_color_pair),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .pending_words   (pending_words),
      .mismatch_count  (mismatch_count)
   );

   // Clock with a period of two time units.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Receiver: drop ready at random according to the current stall rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Guard against a hung handshake.
   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

   // Send one pixel word after a random gap and wait until it is taken.
   task automatic send_pixel(input logic [7:0] r, g, b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every predicted result word has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   // Change the palette mode once the core is empty.
   task automatic write_mode(input logic [2:0] mode);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random pixel, weighted toward greys, saturated colors and threshold levels.
   task automatic pick_pixel(output logic [7:0] r, g, b);
      int kind;
      kind = $urandom_range(99);
      r = 8'($urandom_range(255));
      g = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
      if (kind < 20) begin
         g = r;
         b = r;
      end else if (kind < 35) begin
         r = CORNER_LEVELS[$urandom_range(23)];
         g = r;
         b = r;
      end else if (kind < 47) begin
         r = $urandom_range(1) ? FULL : 8'd0;
         g = $urandom_range(1) ? FULL : 8'd0;
         b = $urandom_range(1) ? FULL : 8'd0;
      end else if (kind < 62) begin
         r = CORNER_LEVELS[$urandom_range(23)];
         g = CORNER_LEVELS[$urandom_range(23)];
         b = CORNER_LEVELS[$urandom_range(23)];
      end else if (kind < 66) begin
         r = MID_GREY;
         g = MID_GREY;
         b = MID_GREY;
      end
   endtask

   // Main sequence: reset, directed pixels, then random segments per mode.
   initial begin
      logic [7:0] r, g, b;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels under the reset mode, with no idling.
      foreach (DIRECTED_PIXELS[i])
         send_pixel(DIRECTED_PIXELS[i][23:16], DIRECTED_PIXELS[i][15:8],
                    DIRECTED_PIXELS[i][7:0]);

      // Random segments, each with its own mode and idling phase.
      for (int seg = 0; seg < 12; seg++) begin
         write_mode(MODE_PLAN[seg]);
         idle_pct  = IDLE_PLAN[seg % 4];
         stall_pct <= STALL_PLAN[seg % 4];
         for (int n = 0; n < 75; n++) begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
            if (seg == 5 && n == 37)
               wait_drained();
         end
      end

      // Let the pipeline empty, then wait on for stray result words.
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
